// ===== hw/rtl/ddpc_pkg.sv =====
// Shared types and constants for the dual dosing pump controller.
`timescale 1ns / 1ps

package ddpc_pkg;

    localparam int SampleW        = 12;
    localparam int TimeW          = 64;
    localparam int IntervalW      = 32;
    localparam int WarnW          = 6;
    localparam int MainsHighLimit = 3500;
    localparam int MainsLowLimit  = 500;

    localparam int CfgAddrW = 5;
    localparam int CfgDataW = 32;

    localparam logic [2*SampleW-1:0] WarnLimitsReset = 24'hFFF000;

    typedef enum logic [2:0] {
        CFG_PH_SETPOINT   = 3'd0,
        CFG_COND_SETPOINT = 3'd1,
        CFG_PH_ON_TIME    = 3'd2,
        CFG_PH_OFF_TIME   = 3'd3,
        CFG_COND_ON_TIME  = 3'd4,
        CFG_COND_OFF_TIME = 3'd5,
        CFG_PH_WARN       = 3'd6,
        CFG_COND_WARN     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [SampleW-1:0]   setpoint;
        logic [IntervalW-1:0] on_time;
        logic [IntervalW-1:0] off_time;
        logic [SampleW-1:0]   warn_hi;
        logic [SampleW-1:0]   warn_lo;
    } t_chan_cfg;

    typedef struct packed {
        logic pump;
        logic active;
        logic warn_lo;
        logic warn_hi;
    } t_chan_stat;

endpackage

// ===== hw/rtl/ddpc_apb_regs.sv =====
// APB configuration registers for both dosing channels.
`timescale 1ns / 1ps

module ddpc_apb_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ddpc_pkg::CfgAddrW-1:0]    paddr,
    input  logic [ddpc_pkg::CfgDataW-1:0]    pwdata,
    output logic [ddpc_pkg::CfgDataW-1:0]    prdata,
    output logic                             pready,
    output ddpc_pkg::t_chan_cfg              o_ph_cfg,
    output ddpc_pkg::t_chan_cfg              o_cond_cfg
);
    import ddpc_pkg::*;

    logic [SampleW-1:0]   r_ph_setpoint, r_cond_setpoint;
    logic [IntervalW-1:0] r_ph_on, r_ph_off, r_cond_on, r_cond_off;
    logic [2*SampleW-1:0] r_ph_warn, r_cond_warn;
    logic                 w_wr;
    t_cfg_idx             w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = t_cfg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph_setpoint   <= '0;
            r_cond_setpoint <= '0;
            r_ph_on         <= '0;
            r_ph_off        <= '0;
            r_cond_on       <= '0;
            r_cond_off      <= '0;
            r_ph_warn       <= WarnLimitsReset;
            r_cond_warn     <= WarnLimitsReset;
        end else if (w_wr) begin
            unique case (w_idx)
                CFG_PH_SETPOINT:   r_ph_setpoint   <= pwdata[SampleW-1:0];
                CFG_COND_SETPOINT: r_cond_setpoint <= pwdata[SampleW-1:0];
                CFG_PH_ON_TIME:    r_ph_on         <= pwdata;
                CFG_PH_OFF_TIME:   r_ph_off        <= pwdata;
                CFG_COND_ON_TIME:  r_cond_on       <= pwdata;
                CFG_COND_OFF_TIME: r_cond_off      <= pwdata;
                CFG_PH_WARN:       r_ph_warn       <= pwdata[2*SampleW-1:0];
                CFG_COND_WARN:     r_cond_warn     <= pwdata[2*SampleW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            CFG_PH_SETPOINT:   prdata = {{(CfgDataW-SampleW){1'b0}}, r_ph_setpoint};
            CFG_COND_SETPOINT: prdata = {{(CfgDataW-SampleW){1'b0}}, r_cond_setpoint};
            CFG_PH_ON_TIME:    prdata = r_ph_on;
            CFG_PH_OFF_TIME:   prdata = r_ph_off;
            CFG_COND_ON_TIME:  prdata = r_cond_on;
            CFG_COND_OFF_TIME: prdata = r_cond_off;
            CFG_PH_WARN:       prdata = {{(CfgDataW-2*SampleW){1'b0}}, r_ph_warn};
            CFG_COND_WARN:     prdata = {{(CfgDataW-2*SampleW){1'b0}}, r_cond_warn};
            default:           prdata = '0;
        endcase
    end

    assign o_ph_cfg   = '{setpoint: r_ph_setpoint, on_time: r_ph_on, off_time: r_ph_off,
                          warn_hi: r_ph_warn[2*SampleW-1:SampleW],
                          warn_lo: r_ph_warn[SampleW-1:0]};
    assign o_cond_cfg = '{setpoint: r_cond_setpoint, on_time: r_cond_on,
                          off_time: r_cond_off,
                          warn_hi: r_cond_warn[2*SampleW-1:SampleW],
                          warn_lo: r_cond_warn[SampleW-1:0]};

endmodule

// ===== hw/rtl/ddpc_channel.sv =====
// One dosing channel: demand bit, pump on/rest timing and sample limit checks.
`timescale 1ns / 1ps

module ddpc_channel (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [ddpc_pkg::TimeW-1:0]     i_now,
    input  logic                           i_sample_valid,
    input  logic [ddpc_pkg::SampleW-1:0]   i_sample,
    input  ddpc_pkg::t_chan_cfg            i_cfg,
    output ddpc_pkg::t_chan_stat           o_stat
);
    import ddpc_pkg::*;

    logic             r_demand, r_active, r_pump;
    logic [TimeW-1:0] r_on_start, r_off_start;
    logic             n_demand, n_active, n_pump;
    logic [TimeW-1:0] n_on_start, n_off_start;
    logic             w_start, w_stop, w_rest;
    logic [TimeW-1:0] w_on_elapsed, w_off_elapsed;

    assign w_on_elapsed  = i_now - r_on_start;
    assign w_off_elapsed = i_now - r_off_start;

    always_comb begin
        n_demand = i_sample_valid ? (i_sample <= i_cfg.setpoint) : r_demand;
        w_start  = !r_pump && n_demand && !r_active;
        // A pump started in this beat has zero elapsed time, so only a pump
        // that was already running can stop; likewise rest needs no stop now.
        w_stop   = r_pump && (w_on_elapsed > {{(TimeW-IntervalW){1'b0}}, i_cfg.on_time});
        n_pump   = (r_pump || w_start) && !w_stop;
        w_rest   = !n_pump && !w_stop &&
                   (w_off_elapsed > {{(TimeW-IntervalW){1'b0}}, i_cfg.off_time});
        n_active    = (r_active || w_start) && !w_rest;
        n_on_start  = w_start ? i_now : r_on_start;
        n_off_start = w_stop ? i_now : r_off_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_demand    <= 1'b0;
            r_active    <= 1'b0;
            r_pump      <= 1'b0;
            r_on_start  <= '0;
            r_off_start <= '0;
        end else if (i_step) begin
            r_demand    <= n_demand;
            r_active    <= n_active;
            r_pump      <= n_pump;
            r_on_start  <= n_on_start;
            r_off_start <= n_off_start;
        end
    end

    assign o_stat = '{pump: n_pump, active: n_active,
                      warn_lo: (i_sample <= i_cfg.warn_lo),
                      warn_hi: (i_sample >= i_cfg.warn_hi)};

`ifndef SYNTHESIS
    a_pump_in_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pump |-> r_active)
        else $error("pump running outside its action phase");
    a_start_stamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_start |=> r_pump && (r_on_start == $past(i_now)))
        else $error("pump start did not record its start time");
    a_stop_stamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_stop |=> !r_pump && (r_off_start == $past(i_now)))
        else $error("pump stop did not record its stop time");
`endif

endmodule

// ===== hw/rtl/dual_dosing_pump_controller.sv =====
// Top level of the dual dosing pump controller: stream ports, stages, warnings.
`timescale 1ns / 1ps
//
// Usage:
//   Input stream (i_s_*): one beat per control step. tdata carries the
//   timestamp and three raw ADC samples; tuser says whether the samples are
//   fresh. Beats without samples still advance the pump timing.
//   Output stream (o_m_*): exactly one beat per input beat, in order, with
//   both pump drive levels, both action phase flags and six warning flags.
//   Configuration: APB port, eight 32-bit registers at byte offsets 0..28.
//   Write them only while no beat is in flight.
// Timing:
//   An accepted beat is held in the input register and, once the output
//   register is free, processed into the output register that drives
//   o_m_tvalid and o_m_tdata. One beat is accepted every cycle while
//   i_m_tready stays high; the channel state update (two 64-bit elapsed-time
//   subtractions per channel) is combinational.
// Reset: synchronous, active low. Pumps off, action phases and demand
//   cleared, warnings zero, limits at their full-range defaults.
// Back-pressure: while i_m_tready is low the result stays on o_m_tdata and
//   the input register can still take one more beat before o_s_tready drops.
//
module dual_dosing_pump_controller #(
    parameter int MAINS_HIGH_LIMIT = ddpc_pkg::MainsHighLimit,
    parameter int MAINS_LOW_LIMIT  = ddpc_pkg::MainsLowLimit
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [63:0] now_time, [75:64] ph_sample, [87:76] cond_sample,
    // [99:88] supply_sample, [103:100] zero
    input  logic [103:0]                   i_s_tdata,
    // [0] sample_valid
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [0] ph_pump_on, [1] cond_pump_on, [2] ph_in_action, [3] cond_in_action,
    // [9:4] warnings, [15:10] zero
    output logic [15:0]                    o_m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ddpc_pkg::CfgAddrW-1:0]  paddr,
    input  logic [ddpc_pkg::CfgDataW-1:0]  pwdata,
    output logic [ddpc_pkg::CfgDataW-1:0]  prdata,
    output logic                           pready
);
    import ddpc_pkg::*;

    localparam logic [SampleW-1:0] MainsHi = SampleW'(MAINS_HIGH_LIMIT);
    localparam logic [SampleW-1:0] MainsLo = SampleW'(MAINS_LOW_LIMIT);

    logic               r_in_valid, r_in_sv;
    logic [TimeW-1:0]   r_in_now;
    logic [SampleW-1:0] r_in_ph, r_in_cond, r_in_supply;
    logic               r_out_valid;
    logic [15:0]        r_out_data;
    logic [WarnW-1:0]   r_warn, n_warn;
    logic               w_out_free, w_advance, w_accept;
    t_chan_cfg          w_ph_cfg, w_cond_cfg;
    t_chan_stat         w_ph_stat, w_cond_stat;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;

    ddpc_apb_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_ph_cfg   (w_ph_cfg),
        .o_cond_cfg (w_cond_cfg)
    );

    ddpc_channel u_ph (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_advance),
        .i_now          (r_in_now),
        .i_sample_valid (r_in_sv),
        .i_sample       (r_in_ph),
        .i_cfg          (w_ph_cfg),
        .o_stat         (w_ph_stat)
    );

    ddpc_channel u_cond (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_advance),
        .i_now          (r_in_now),
        .i_sample_valid (r_in_sv),
        .i_sample       (r_in_cond),
        .i_cfg          (w_cond_cfg),
        .o_stat         (w_cond_stat)
    );

    always_comb begin
        n_warn = r_warn;
        if (r_in_sv) begin
            n_warn = {(r_in_supply <= MainsLo), (r_in_supply >= MainsHi),
                      w_cond_stat.warn_lo, w_cond_stat.warn_hi,
                      w_ph_stat.warn_lo, w_ph_stat.warn_hi};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_warn      <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_warn      <= n_warn;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_now    <= i_s_tdata[63:0];
            r_in_ph     <= i_s_tdata[75:64];
            r_in_cond   <= i_s_tdata[87:76];
            r_in_supply <= i_s_tdata[99:88];
            r_in_sv     <= i_s_tuser;
        end
        if (w_advance) begin
            r_out_data <= {6'b0, n_warn, w_cond_stat.active, w_ph_stat.active,
                           w_cond_stat.pump, w_ph_stat.pump};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_out_pump_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (!o_m_tdata[0] || o_m_tdata[2]) && (!o_m_tdata[1] || o_m_tdata[3]))
        else $error("result shows a pump on outside its action phase");
    a_out_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_advance))
        else $error("result appeared without a processed beat");
    a_warn_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_advance && r_in_sv) |=> $stable(r_warn))
        else $error("warning flags changed without a sample set");
`endif

endmodule

// ===== test/ddpc_checker.sv =====
// Checker for the dual dosing pump controller: predicts each result beat and compares it.
`timescale 1ns / 1ps

module ddpc_checker
    import ddpc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    // [63:0] now_time, [75:64] ph_sample, [87:76] cond_sample,
    // [99:88] supply_sample, [103:100] zero
    input  logic [103:0]        i_s_tdata,
    // [0] sample_valid
    input  logic                i_s_tuser,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    // [0] ph_pump_on, [1] cond_pump_on, [2] ph_in_action, [3] cond_in_action,
    // [9:4] warnings, [15:10] zero
    input  logic [15:0]         i_m_tdata,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [CfgAddrW-1:0] i_paddr,
    input  logic [CfgDataW-1:0] i_pwdata,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        logic [SampleW-1:0]   setpoint;
        logic [IntervalW-1:0] on_time;
        logic [IntervalW-1:0] off_time;
        logic [SampleW-1:0]   warn_hi;
        logic [SampleW-1:0]   warn_lo;
        logic                 demand;
        logic                 active;
        logic                 pump;
        logic [TimeW-1:0]     on_start;
        logic [TimeW-1:0]     off_start;
    } t_dose_chan;

    // Same bit order as the result beat, lowest field last.
    typedef struct packed {
        logic [WarnW-1:0] warnings;
        logic             cond_in_action;
        logic             ph_in_action;
        logic             cond_pump_on;
        logic             ph_pump_on;
    } t_pump_status;

    t_dose_chan       ph_chan;
    t_dose_chan       cond_chan;
    logic [WarnW-1:0] warn_flags;
    t_pump_status     status_q[$];
    int               fail_count = 0;

    assign o_fail_count = fail_count;

    // Start, stop and rest rules of one channel; elapsed times wrap modulo 2^64.
    function automatic t_dose_chan advance_channel(input t_dose_chan ch,
                                                   input logic [TimeW-1:0] now);
        if (!ch.pump && ch.demand && !ch.active) begin
            ch.pump     = 1'b1;
            ch.on_start = now;
            ch.active   = 1'b1;
        end
        if (ch.pump && (now - ch.on_start) > {32'd0, ch.on_time}) begin
            ch.pump      = 1'b0;
            ch.off_start = now;
        end
        if (!ch.pump && (now - ch.off_start) > {32'd0, ch.off_time}) begin
            ch.active = 1'b0;
        end
        return ch;
    endfunction

    task automatic check_field(input string name, input logic [WarnW-1:0] want,
                               input logic [WarnW-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        logic [TimeW-1:0]   now;
        logic [SampleW-1:0] ph_raw;
        logic [SampleW-1:0] cond_raw;
        logic [SampleW-1:0] supply_raw;
        t_pump_status       got;
        t_pump_status       want;
        if (!i_rst_n) begin
            ph_chan   = '0;
            cond_chan = '0;
            {ph_chan.warn_hi, ph_chan.warn_lo}     = WarnLimitsReset;
            {cond_chan.warn_hi, cond_chan.warn_lo} = WarnLimitsReset;
            warn_flags = '0;
            status_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_cfg_idx'(i_paddr[CfgAddrW-1:2]))
                    CFG_PH_SETPOINT:   ph_chan.setpoint   = i_pwdata[SampleW-1:0];
                    CFG_COND_SETPOINT: cond_chan.setpoint = i_pwdata[SampleW-1:0];
                    CFG_PH_ON_TIME:    ph_chan.on_time    = i_pwdata;
                    CFG_PH_OFF_TIME:   ph_chan.off_time   = i_pwdata;
                    CFG_COND_ON_TIME:  cond_chan.on_time  = i_pwdata;
                    CFG_COND_OFF_TIME: cond_chan.off_time = i_pwdata;
                    CFG_PH_WARN:       {ph_chan.warn_hi, ph_chan.warn_lo} = i_pwdata[23:0];
                    CFG_COND_WARN: {cond_chan.warn_hi, cond_chan.warn_lo} = i_pwdata[23:0];
                    default: ;
                endcase
            end

            if (i_m_tvalid && i_m_tready) begin
                got = t_pump_status'(i_m_tdata[9:0]);
                if (status_q.size() == 0) begin
                    $error("result beat %h arrived with no expectation", i_m_tdata);
                    fail_count++;
                end else begin
                    want = status_q.pop_front();
                    check_field("ph_pump_on", 6'(want.ph_pump_on), 6'(got.ph_pump_on));
                    check_field("cond_pump_on", 6'(want.cond_pump_on), 6'(got.cond_pump_on));
                    check_field("ph_in_action", 6'(want.ph_in_action), 6'(got.ph_in_action));
                    check_field("cond_in_action", 6'(want.cond_in_action),
                                6'(got.cond_in_action));
                    check_field("warnings", want.warnings, got.warnings);
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                now        = i_s_tdata[63:0];
                ph_raw     = i_s_tdata[75:64];
                cond_raw   = i_s_tdata[87:76];
                supply_raw = i_s_tdata[99:88];
                // A fresh sample set replaces the warnings; otherwise they hold.
                if (i_s_tuser) begin
                    warn_flags = {int'(supply_raw) <= MainsLowLimit,
                                  int'(supply_raw) >= MainsHighLimit,
                                  cond_raw <= cond_chan.warn_lo,
                                  cond_raw >= cond_chan.warn_hi,
                                  ph_raw <= ph_chan.warn_lo,
                                  ph_raw >= ph_chan.warn_hi};
                    ph_chan.demand   = (ph_raw <= ph_chan.setpoint);
                    cond_chan.demand = (cond_raw <= cond_chan.setpoint);
                end
                ph_chan   = advance_channel(ph_chan, now);
                cond_chan = advance_channel(cond_chan, now);
                want.ph_pump_on     = ph_chan.pump;
                want.cond_pump_on   = cond_chan.pump;
                want.ph_in_action   = ph_chan.active;
                want.cond_in_action = cond_chan.active;
                want.warnings       = warn_flags;
                status_q.push_back(want);
            end
        end
        o_pending = status_q.size();
    end

endmodule

// ===== test/dual_dosing_pump_controller_test.sv =====
// Testbench top for the dual dosing pump controller: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module dual_dosing_pump_controller_test;
    import ddpc_pkg::*;

    localparam int QuietLimit = 2000;
    localparam int HoldCycles = 40;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    // [63:0] now_time, [75:64] ph_sample, [87:76] cond_sample,
    // [99:88] supply_sample, [103:100] zero
    logic [103:0]        i_s_tdata;
    // [0] sample_valid
    logic                i_s_tuser;
    logic                o_m_tvalid;
    logic                i_m_tready;
    // [0] ph_pump_on, [1] cond_pump_on, [2] ph_in_action, [3] cond_in_action,
    // [9:4] warnings, [15:10] zero
    logic [15:0]         o_m_tdata;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CfgAddrW-1:0] paddr;
    logic [CfgDataW-1:0] pwdata;
    logic [CfgDataW-1:0] prdata;
    logic                pready;

    int         fail_count;
    int         pending;
    int         quiet_cycles = 0;
    bit         src_gaps;
    bit         sink_gaps;
    bit         hold_req;
    logic [63:0] stamp;
    // Current settings, used to aim samples at the interesting thresholds.
    logic [11:0] ph_sp;
    logic [11:0] cond_sp;
    logic [23:0] ph_warn;
    logic [23:0] cond_warn;

    dual_dosing_pump_controller u_dut (.*);

    ddpc_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_tready = 1'b0;
                repeat (HoldCycles) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_m_tready = !sink_gaps || ($urandom_range(99, 0) >= 36);
        end
    end

    // Setup phase, then access phase; the register is written when pready is seen.
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [31:0] sp_ph, input logic [31:0] sp_cond,
                                  input logic [31:0] on_ph, input logic [31:0] off_ph,
                                  input logic [31:0] on_cond, input logic [31:0] off_cond,
                                  input logic [31:0] warn_ph, input logic [31:0] warn_cond);
        write_reg(CFG_PH_SETPOINT, sp_ph);
        write_reg(CFG_COND_SETPOINT, sp_cond);
        write_reg(CFG_PH_ON_TIME, on_ph);
        write_reg(CFG_PH_OFF_TIME, off_ph);
        write_reg(CFG_COND_ON_TIME, on_cond);
        write_reg(CFG_COND_OFF_TIME, off_cond);
        write_reg(CFG_PH_WARN, warn_ph);
        write_reg(CFG_COND_WARN, warn_cond);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        ph_sp     = sp_ph[11:0];
        cond_sp   = sp_cond[11:0];
        ph_warn   = warn_ph[23:0];
        cond_warn = warn_cond[23:0];
    endtask

    // Stops offering beats and waits until every result has come back.
    task automatic drain();
        i_s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic send_step(input logic [63:0] now, input logic fresh,
                             input logic [11:0] ph, input logic [11:0] cond,
                             input logic [11:0] supply);
        while (src_gaps && ($urandom_range(99, 0) < 36)) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = fresh;
        i_s_tdata  = {4'h0, supply, cond, ph, now};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    function automatic logic [11:0] pick_sample(input logic [11:0] pivot_a,
                                                input logic [11:0] pivot_b);
        case ($urandom_range(3, 0))
            0: return 12'($urandom);
            1: return pivot_a + 12'($urandom_range(4, 0)) - 12'd2;
            2: return pivot_b + 12'($urandom_range(4, 0)) - 12'd2;
            default: return $urandom_range(1, 0) ? 12'hFFF : 12'h000;
        endcase
    endfunction

    function automatic logic [31:0] pick_interval();
        return $urandom_range(1, 0) ? 32'($urandom_range(60, 0)) : $urandom;
    endfunction

    task automatic run_phase(input int n_items, input int max_step);
        int          r;
        logic [11:0] ph;
        logic [11:0] cond;
        logic [11:0] supply;
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(99, 0);
            // Mostly small forward steps; some jumps past a 32-bit interval, some anywhere.
            if (r < 3) begin
                stamp = {$urandom, $urandom};
            end else if (r < 8) begin
                stamp += {31'h0, 1'($urandom_range(1, 0)), $urandom};
            end else begin
                stamp += 64'($urandom_range(max_step, 0));
            end
            ph     = pick_sample(ph_sp, $urandom_range(1, 0) ? ph_warn[11:0] : ph_warn[23:12]);
            cond   = pick_sample(cond_sp,
                                 $urandom_range(1, 0) ? cond_warn[11:0] : cond_warn[23:12]);
            supply = pick_sample(12'(MainsHighLimit), 12'(MainsLowLimit));
            send_step(stamp, $urandom_range(99, 0) < 70, ph, cond, supply);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        src_gaps   = 1'b1;
        sink_gaps  = 1'b1;
        hold_req   = 1'b0;
        stamp      = '0;
        ph_sp      = '0;
        cond_sp    = '0;
        ph_warn    = WarnLimitsReset;
        cond_warn  = WarnLimitsReset;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: zero setpoints and intervals, full-range warning limits.
        send_step(64'd0, 1'b1, 12'd0, 12'd0, 12'd0);
        send_step(64'd1, 1'b0, 12'hFFF, 12'hFFF, 12'hFFF);
        send_step(64'd1, 1'b0, 12'd0, 12'd0, 12'd0);
        send_step(64'd2, 1'b0, 12'd0, 12'd0, 12'd0);
        send_step(64'd3, 1'b1, 12'hFFF, 12'hFFF, 12'hFFF);
        send_step(64'd4, 1'b1, 12'd1, 12'd1, 12'd3500);
        send_step(64'd5, 1'b1, 12'd0, 12'd4094, 12'd3499);
        send_step(64'd6, 1'b1, 12'd4094, 12'd0, 12'd500);
        send_step(64'd7, 1'b1, 12'd2048, 12'd2048, 12'd501);
        send_step(64'd8, 1'b0, 12'd0, 12'd0, 12'd0);
        send_step(64'd9, 1'b0, 12'd0, 12'd0, 12'd0);
        // Timestamp wrap: start at the top of the range, stop and rest after it.
        send_step(64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 12'd0, 12'd0, 12'd2000);
        send_step(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 12'd0, 12'd0, 12'd2000);
        send_step(64'd0, 1'b0, 12'd0, 12'd0, 12'd0);
        send_step(64'd0, 1'b0, 12'd0, 12'd0, 12'd0);
        send_step(64'd1, 1'b0, 12'd0, 12'd0, 12'd0);
        send_step(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 12'hFFF, 12'hFFF, 12'hFFF);
        send_step(64'd5, 1'b1, 12'd0, 12'hFFF, 12'd0);
        send_step(64'd5, 1'b1, 12'hFFF, 12'd0, 12'hFFF);
        send_step(64'd6, 1'b0, 12'hFFF, 12'hFFF, 12'hFFF);
        stamp = 64'd10;
        run_phase(100, 8);

        // Moderate settings; the receiver holds off while the sender keeps going.
        drain();
        apply_settings(32'd2048, 32'd1000, 32'd20, 32'd30, 32'd5, 32'd50,
                       {8'h0, 12'd3000, 12'd1000}, {8'h0, 12'd3500, 12'd600});
        hold_req = 1'b1;
        run_phase(150, 10);

        // Extremes with junk above the register widths, and no gaps on either side.
        drain();
        apply_settings(32'hFFFF_FFFF, 32'hABCD_EFFF, 32'd0, 32'd0, 32'd0, 32'd0,
                       32'hFFFF_FFFF, 32'hFF00_0000);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        run_phase(150, 3);
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;

        // Longest on-times and pH off-time; only big timestamp jumps end a dosing cycle.
        drain();
        apply_settings(32'd3000, 32'd3000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'd1, $urandom, $urandom);
        run_phase(75, 1000);
        drain();
        run_phase(75, 1000);

        for (int p = 0; p < 3; p++) begin
            drain();
            apply_settings($urandom, $urandom, pick_interval(), pick_interval(),
                           pick_interval(), pick_interval(), $urandom, $urandom);
            run_phase(150, 20);
        end

        drain();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ddpc_pkg.sv
hw/rtl/ddpc_apb_regs.sv
hw/rtl/ddpc_channel.sv
hw/rtl/dual_dosing_pump_controller.sv
test/ddpc_checker.sv
test/dual_dosing_pump_controller_test.sv
